// File: src/tfn_pkg.sv
`default_nettype none
package tfn_pkg;

	// vertex coordinate width (Q8.8 at 16 bits)
	localparam int COORD_WIDTH = 16;

	// edge difference and its magnitude
	localparam int EDGE_W = COORD_WIDTH + 1;
	localparam int MAG_W = COORD_WIDTH;

	// edges are reduced below 2^31 before the cross product
	localparam int RED_W = (MAG_W > 31) ? 31 : MAG_W;
	localparam int RED_SHIFT_MAX = MAG_W - RED_W;
	localparam int SH_W = $clog2(RED_SHIFT_MAX + 2);
	localparam int RE_W = RED_W + 1;

	// cross product
	localparam int PROD_W = 2 * RE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int CMAG_W = 2 * RED_W + 1;

	// normalization: largest magnitude lands in [2^29, 2^30)
	localparam int U_W = 30;
	localparam int NORM_MSB = 29;
	localparam int P_W = $clog2(CMAG_W);
	localparam int WIDE_W = CMAG_W + NORM_MSB;

	// sum of squares and square root
	localparam int SQ_W = 2 * U_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int ROOT_W = 31;
	localparam int REM_W = 64;

	// final divide
	localparam int FRAC_W = 14;
	localparam int ONE_Q14 = 16384;
	localparam int Q_W = 15;
	localparam int NUM_W = U_W + FRAC_W + 1;
	localparam int OUT_W = 16;

	// per-item data carried alongside the root computation
	typedef struct packed {
		logic [2:0][U_W-1:0] u;
		logic [2:0]          neg;
		logic                degen;
	} side_t;

	// right shift that brings the largest edge magnitude below 2^31
	function automatic logic [SH_W-1:0] red_shift(input logic [MAG_W-1:0] m);
		logic [SH_W-1:0] sh;
		sh = '0;
		for (int i = 0; i < RED_SHIFT_MAX; i++) begin
			if ((m >> (RED_W + i)) != '0) sh = SH_W'(i + 1);
		end
		return sh;
	endfunction

endpackage
`default_nettype wire

// File: src/tfn_isqrt.sv
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module tfn_isqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic [tfn_pkg::SUM_W-1:0]  s,
	input  wire tfn_pkg::side_t             in_side,
	output logic                            out_valid,
	output logic [tfn_pkg::ROOT_W-1:0]      root,
	output tfn_pkg::side_t                  out_side
);

	localparam int N = tfn_pkg::ROOT_W;

	logic [N-1:0]                   v_s;
	logic [tfn_pkg::REM_W-1:0]      rem_s  [N];
	logic [N-1:0]                   r_s    [N];
	tfn_pkg::side_t                 side_s [N];

	// valid bits per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int B = N - 1 - k;
		logic [tfn_pkg::REM_W-1:0] rem_in, trial;
		logic [N-1:0]              r_in;
		tfn_pkg::side_t            side_in;

		if (k == 0) begin : g_first
			assign rem_in  = tfn_pkg::REM_W'(s);
			assign r_in    = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign r_in    = r_s[k-1];
			assign side_in = side_s[k-1];
		end

		// (r + 2^b)^2 - r^2
		assign trial = (tfn_pkg::REM_W'(r_in) << (B + 1)) + (tfn_pkg::REM_W'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_in;
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					r_s[k]   <= r_in | (N'(1) << B);
				end else begin
					rem_s[k] <= rem_in;
					r_s[k]   <= r_in;
				end
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign root      = r_s[N-1];
	assign out_side  = side_s[N-1];

endmodule
`default_nettype wire

// File: src/triangle_face_normal.sv
`default_nettype none
// Triangle face normal.
// Input channel (in_valid/in_ready) takes the three vertices A, B, C as
// signed Q8.8 coordinates ax..cz. Output channel (out_valid/out_ready)
// returns the unit normal of (B-A) x (C-A) as signed Q1.14 nx, ny, nz,
// plus degenerate, set with a zero normal when the cross product is zero.
// One result per transaction, in order.
// Throughput: one transaction per cycle while out_ready does not stall the
// pipeline. Stages: 6 front stages, one stage per root bit (31), one stage
// per quotient bit (15) and the output register.
// Reset clears all valid bits; no result is pending afterwards.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated.
module triangle_face_normal (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] ax,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] ay,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] az,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] bx,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] by,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] bz,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] cx,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] cy,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] cz,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [tfn_pkg::OUT_W-1:0]      nx,
	output logic signed [tfn_pkg::OUT_W-1:0]      ny,
	output logic signed [tfn_pkg::OUT_W-1:0]      nz,
	output logic                                  degenerate
);

	localparam int EW  = tfn_pkg::EDGE_W;
	localparam int NQ  = tfn_pkg::Q_W;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- stage 1: edges and reduction ----------------
	logic signed [EW-1:0] e1 [3], e2 [3];
	logic signed [tfn_pkg::RE_W-1:0] re1_c [3], re2_c [3];
	logic signed [tfn_pkg::RE_W-1:0] e1_s1 [3], e2_s1 [3];
	logic v_s1;

	always_comb begin
		logic [tfn_pkg::MAG_W-1:0] m1 [3], m2 [3];
		logic [tfn_pkg::MAG_W-1:0] or1, or2;
		logic [tfn_pkg::SH_W-1:0]  sh1, sh2;
		logic [tfn_pkg::RED_W-1:0] r1, r2;
		e1[0] = EW'(bx) - EW'(ax);
		e1[1] = EW'(by) - EW'(ay);
		e1[2] = EW'(bz) - EW'(az);
		e2[0] = EW'(cx) - EW'(ax);
		e2[1] = EW'(cy) - EW'(ay);
		e2[2] = EW'(cz) - EW'(az);
		or1 = '0;
		or2 = '0;
		for (int i = 0; i < 3; i++) begin
			m1[i] = e1[i][EW-1] ? tfn_pkg::MAG_W'(-e1[i]) : tfn_pkg::MAG_W'(e1[i]);
			m2[i] = e2[i][EW-1] ? tfn_pkg::MAG_W'(-e2[i]) : tfn_pkg::MAG_W'(e2[i]);
			or1 = or1 | m1[i];
			or2 = or2 | m2[i];
		end
		sh1 = tfn_pkg::red_shift(or1);
		sh2 = tfn_pkg::red_shift(or2);
		for (int i = 0; i < 3; i++) begin
			r1 = tfn_pkg::RED_W'(m1[i] >> sh1);
			r2 = tfn_pkg::RED_W'(m2[i] >> sh2);
			re1_c[i] = e1[i][EW-1] ? -$signed({1'b0, r1}) : $signed({1'b0, r1});
			re2_c[i] = e2[i][EW-1] ? -$signed({1'b0, r2}) : $signed({1'b0, r2});
		end
	end

	// ---------------- stage 2: six products ----------------
	logic signed [tfn_pkg::PROD_W-1:0] p_s2 [6];
	logic v_s2;

	// ---------------- stage 3: cross magnitudes and signs ----------------
	logic [tfn_pkg::CMAG_W-1:0] cm_s3 [3];
	logic [2:0] neg_s3;
	logic v_s3;

	logic signed [tfn_pkg::CROSS_W-1:0] cr_c [3];
	always_comb begin
		cr_c[0] = tfn_pkg::CROSS_W'(p_s2[0]) - tfn_pkg::CROSS_W'(p_s2[1]);
		cr_c[1] = tfn_pkg::CROSS_W'(p_s2[2]) - tfn_pkg::CROSS_W'(p_s2[3]);
		cr_c[2] = tfn_pkg::CROSS_W'(p_s2[4]) - tfn_pkg::CROSS_W'(p_s2[5]);
	end

	// ---------------- stage 4: normalize ----------------
	tfn_pkg::side_t side_s4;
	logic v_s4;
	tfn_pkg::side_t side_c4;

	always_comb begin
		logic [tfn_pkg::CMAG_W-1:0] orm;
		logic [tfn_pkg::P_W-1:0]    p;
		logic [tfn_pkg::WIDE_W-1:0] w;
		orm = cm_s3[0] | cm_s3[1] | cm_s3[2];
		p = '0;
		for (int i = 0; i < tfn_pkg::CMAG_W; i++) begin
			if (orm[i]) p = tfn_pkg::P_W'(i);
		end
		for (int i = 0; i < 3; i++) begin
			w = (tfn_pkg::WIDE_W'(cm_s3[i]) << tfn_pkg::NORM_MSB) >> p;
			side_c4.u[i] = w[tfn_pkg::U_W-1:0];
		end
		side_c4.neg   = neg_s3;
		side_c4.degen = (orm == '0);
	end

	// ---------------- stage 5: squares ----------------
	logic [tfn_pkg::SQ_W-1:0] sq_s5 [3];
	tfn_pkg::side_t side_s5;
	logic v_s5;

	// ---------------- stage 6: sum ----------------
	logic [tfn_pkg::SUM_W-1:0] sum_s6;
	tfn_pkg::side_t side_s6;
	logic v_s6;

	// datapath registers for the front stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= re1_c[i];
				e2_s1[i] <= re2_c[i];
			end
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= cr_c[i][tfn_pkg::CROSS_W-1];
				cm_s3[i]  <= cr_c[i][tfn_pkg::CROSS_W-1] ?
					tfn_pkg::CMAG_W'(-cr_c[i]) : tfn_pkg::CMAG_W'(cr_c[i]);
			end
			side_s4 <= side_c4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= tfn_pkg::SQ_W'(side_s4.u[i]) * tfn_pkg::SQ_W'(side_s4.u[i]);
			end
			side_s5 <= side_s4;
			sum_s6  <= tfn_pkg::SUM_W'(sq_s5[0]) + tfn_pkg::SUM_W'(sq_s5[1])
				+ tfn_pkg::SUM_W'(sq_s5[2]);
			side_s6 <= side_s5;
		end
	end

	// ---------------- square root ----------------
	logic                         vr;
	logic [tfn_pkg::ROOT_W-1:0]   len;
	tfn_pkg::side_t               side_r;

	tfn_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.s         (sum_s6),
		.in_side   (side_s6),
		.out_valid (vr),
		.root      (len),
		.out_side  (side_r)
	);

	// ---------------- divide: one quotient bit per stage ----------------
	logic [NQ-1:0]                 vd_s;
	logic [tfn_pkg::NUM_W-1:0]     rem_d [NQ][3];
	logic [NQ-1:0]                 q_d   [NQ][3];
	logic [tfn_pkg::ROOT_W-1:0]    len_d [NQ];
	logic [2:0]                    neg_d [NQ];
	logic                          dg_d  [NQ];

	for (genvar k = 0; k < NQ; k++) begin : g_div
		localparam int J = NQ - 1 - k;
		logic [tfn_pkg::NUM_W-1:0] rem_in [3];
		logic [NQ-1:0]             q_in   [3];
		logic [tfn_pkg::ROOT_W-1:0] l_in;
		logic [tfn_pkg::NUM_W-1:0] dv;
		logic [2:0]                neg_in;
		logic                      dg_in;

		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem_in[i] = (tfn_pkg::NUM_W'(side_r.u[i]) << tfn_pkg::FRAC_W)
						+ tfn_pkg::NUM_W'(len >> 1);
					q_in[i] = '0;
				end
			end
			assign l_in   = len;
			assign neg_in = side_r.neg;
			assign dg_in  = side_r.degen;
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem_in[i] = rem_d[k-1][i];
					q_in[i]   = q_d[k-1][i];
				end
			end
			assign l_in   = len_d[k-1];
			assign neg_in = neg_d[k-1];
			assign dg_in  = dg_d[k-1];
		end

		assign dv = tfn_pkg::NUM_W'(l_in) << J;

		always_ff @(posedge clk) begin
			if (en) begin
				len_d[k] <= l_in;
				neg_d[k] <= neg_in;
				dg_d[k]  <= dg_in;
				for (int i = 0; i < 3; i++) begin
					if (rem_in[i] >= dv) begin
						rem_d[k][i] <= rem_in[i] - dv;
						q_d[k][i]   <= q_in[i] | (NQ'(1) << J);
					end else begin
						rem_d[k][i] <= rem_in[i];
						q_d[k][i]   <= q_in[i];
					end
				end
			end
		end
	end

	// ---------------- output register ----------------
	logic signed [tfn_pkg::OUT_W-1:0] n_c [3];
	always_comb begin
		logic [NQ-1:0] q;
		for (int i = 0; i < 3; i++) begin
			q = (q_d[NQ-1][i] > NQ'(tfn_pkg::ONE_Q14)) ? NQ'(tfn_pkg::ONE_Q14) : q_d[NQ-1][i];
			if (dg_d[NQ-1]) n_c[i] = '0;
			else if (neg_d[NQ-1][i]) n_c[i] = -$signed(tfn_pkg::OUT_W'(q));
			else n_c[i] = $signed(tfn_pkg::OUT_W'(q));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx         <= n_c[0];
			ny         <= n_c[1];
			nz         <= n_c[2];
			degenerate <= dg_d[NQ-1];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			vd_s      <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			vd_s      <= {vd_s[NQ-2:0], vr};
			out_valid <= vd_s[NQ-1];
		end
	end

	// degenerate results carry a zero normal
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> nx == '0 && ny == '0 && nz == '0)
		else $error("degenerate result with nonzero normal");

	// components stay within unit range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nx >= -16'sd16384 && nx <= 16'sd16384
			&& ny >= -16'sd16384 && ny <= 16'sd16384
			&& nz >= -16'sd16384 && nz <= 16'sd16384)
		else $error("normal component out of range");

	// no transaction is taken while a result is stalled
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted during output stall");

	// a stalled result keeps its flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(degenerate))
		else $error("stalled result changed");

endmodule
`default_nettype wire

// File: tb/triangle_face_normal_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module triangle_face_normal_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_ready,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] ax, ay, az,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] bx, by, bz,
	input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0] cx, cy, cz,
	input  wire logic out_valid,
	input  wire logic out_ready,
	input  wire logic signed [15:0] nx, ny, nz,
	input  wire logic degenerate,
	output int errors,
	output int pending
);

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               degen;
	} normal_t;

	normal_t normal_q[$];

	assign pending = normal_q.size();

	// integer square root, floor
	function automatic longint unsigned floor_sqrt(input longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// unit normal of (B-A) x (C-A); edges fit in 17 bits so no reduction
	function automatic normal_t face_normal(input longint a[3], input longint b[3],
			input longint c[3]);
		longint e1[3], e2[3], cr[3];
		longint unsigned u[3], m, s, len, n;
		logic signed [15:0] comp[3];
		normal_t r;
		for (int i = 0; i < 3; i++) begin
			e1[i] = b[i] - a[i];
			e2[i] = c[i] - a[i];
		end
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		m = 0;
		for (int i = 0; i < 3; i++) begin
			u[i] = cr[i] < 0 ? -cr[i] : cr[i];
			if (u[i] > m) m = u[i];
		end
		if (m == 0) begin
			r = '0;
			r.degen = 1'b1;
			return r;
		end
		while (m >= 64'd1073741824) begin
			m >>= 1;
			for (int i = 0; i < 3; i++) u[i] >>= 1;
		end
		while (m < 64'd536870912) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) u[i] <<= 1;
		end
		s = 0;
		for (int i = 0; i < 3; i++) s += u[i] * u[i];
		len = floor_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			n = (u[i] * 16384 + (len >> 1)) / len;
			if (n > 16384) n = 16384;
			comp[i] = cr[i] < 0 ? -16'(n) : 16'(n);
		end
		r.nx = comp[0];
		r.ny = comp[1];
		r.nz = comp[2];
		r.degen = 1'b0;
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial errors = 0;

	// predict on input transaction, compare on output transaction
	always @(posedge clk) begin
		normal_t want;
		if (arst_n && in_valid && in_ready)
			normal_q.push_back(face_normal('{ax, ay, az}, '{bx, by, bz}, '{cx, cy, cz}));
		if (arst_n && out_valid && out_ready) begin
			if (normal_q.size() == 0) begin
				$display("%0t unexpected output transaction", $realtime);
				errors++;
			end else begin
				want = normal_q.pop_front();
				if (nx !== want.nx) report("nx", nx, want.nx);
				if (ny !== want.ny) report("ny", ny, want.ny);
				if (nz !== want.nz) report("nz", nz, want.nz);
				if (degenerate !== want.degen) report("degenerate", degenerate, want.degen);
			end
		end
	end
endmodule
`default_nettype wire

// File: tb/triangle_face_normal_test.sv
`timescale 1ns / 100ps
`default_nettype none
module triangle_face_normal_test;

	localparam int N_RANDOM = 1430;
	localparam int LATENCY = 53;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready, out_valid, degenerate;
	logic signed [tfn_pkg::COORD_WIDTH-1:0] ax = '0, ay = '0, az = '0;
	logic signed [tfn_pkg::COORD_WIDTH-1:0] bx = '0, by = '0, bz = '0;
	logic signed [tfn_pkg::COORD_WIDTH-1:0] cx = '0, cy = '0, cz = '0;
	logic signed [15:0] nx, ny, nz;
	int errors, pending;
	bit stim_done = 1'b0;
	bit hold_off = 1'b0;

	always #5 clk = ~clk;

	triangle_face_normal u_dut (.*);

	triangle_face_normal_checker u_check (.*);

	function automatic int gap_len();
		if ($urandom_range(9) < 6) return 0;
		if ($urandom_range(9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// offer one triangle and wait for the input transaction
	task automatic send_tri(input logic [8:0][15:0] v);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		{ax, ay, az, bx, by, bz, cx, cy, cz} <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// receiver: random stalls, plus one long hold-off early on
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			out_ready <= ($urandom_range(3) != 0) || gap_len() == 0;
			@(posedge clk);
		end
	end

	initial begin
		logic [15:0] p, q, r;
		logic [15:0] v[9];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: axis normals, extremes, degenerate shapes
		send_tri({16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0});
		send_tri({16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd256, 16'd0, 16'd0});
		send_tri({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0});
		send_tri({16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd2, 16'd2, 16'd2});
		send_tri({9{16'h1234}});
		send_tri({16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd9, 16'd1, 16'd3});
		send_tri({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
			16'h8000, 16'h7fff, 16'h8000});
		send_tri({16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h8000, 16'h8000, 16'h7fff});
		send_tri({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
			16'h8000, 16'h8000, 16'h8000});
		send_tri({16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h8000, 16'h0001,
			16'h0001, 16'h7fff, 16'h8000});
		send_tri({16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1});
		send_tri({16'd0, 16'd0, 16'd0, 16'd3, 16'd4, 16'd0, 16'hfffc, 16'd3, 16'd0});
		hold_off = 1'b1;
		// random: mostly generic, some collinear or repeated vertices
		for (int k = 0; k < N_RANDOM; k++) begin
			foreach (v[i]) v[i] = rand_coord();
			case ($urandom_range(9))
				0: begin
					v[3] = v[0];
					v[4] = v[1];
					v[5] = v[2];
				end
				1: begin
					p = 16'($signed($urandom_range(0, 20)) - 10);
					q = 16'($signed($urandom_range(0, 20)) - 10);
					r = 16'($signed($urandom_range(0, 20)) - 10);
					v[3] = v[0] + p;         v[4] = v[1] + q;         v[5] = v[2] + r;
					v[6] = v[0] - (p << 1);  v[7] = v[1] - (q << 1);  v[8] = v[2] - (r << 1);
				end
				default: ;
			endcase
			send_tri({v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]});
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// verdict
	initial begin
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("triangle_face_normal regression: pass");
		else
			$display("triangle_face_normal regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("triangle_face_normal regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
